### rtl/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg
// shared widths, command codes and character codes of the text console writer
// ----------------------------------------------------------------------------
package tcw_pkg;

   // default screen geometry
   localparam int DEF_COLUMNS = 80;
   localparam int DEF_ROWS    = 25;

   // fixed port widths
   localparam int CMD_W       = 1;
   localparam int CH_W        = 8;
   localparam int IDX_W       = 11;
   localparam int ROW_W       = 5;
   localparam int COL_W       = 7;
   localparam int POS_W       = 11;
   localparam int ATTR_W      = 8;
   localparam int COLOR_W     = 4;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 4;

   // commands
   localparam logic [CMD_W-1:0] CMD_PUT  = 1'b0;
   localparam logic [CMD_W-1:0] CMD_READ = 1'b1;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_FG_COLOR = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] REG_BG_COLOR = 1'b1;

   // character codes
   localparam logic [CH_W-1:0] CH_BS    = 8'h08;
   localparam logic [CH_W-1:0] CH_TAB   = 8'h09;
   localparam logic [CH_W-1:0] CH_NL    = 8'h0A;
   localparam logic [CH_W-1:0] CH_ESC   = 8'h1B;
   localparam logic [CH_W-1:0] CH_SPACE = 8'h20;

   // attributes
   localparam logic [ATTR_W-1:0] ATTR_RESET  = 8'h0F;
   localparam logic [ATTR_W-1:0] ATTR_SCROLL = 8'h07;

   // color register reset values
   localparam logic [COLOR_W-1:0] FG_RESET = 4'hF;
   localparam logic [COLOR_W-1:0] BG_RESET = 4'h0;

endpackage

### rtl/tcw_ram.sv
// ----------------------------------------------------------------------------
// tcw_ram
// generic single write port, single read port ram with registered read data
// ----------------------------------------------------------------------------
module tcw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/text_console_writer.sv
// ----------------------------------------------------------------------------
// text_console_writer
// text-mode console: a cell store of character and attribute bytes plus a
// cursor, driven by put and read commands, one response beat per command
// ----------------------------------------------------------------------------
//
//  channel   ports                              handshake
//  --------  ---------------------------------  ------------------------------
//  request   req_cmd, req_ch, req_cell_index    beat taken when start & !busy
//  response  rsp_cursor_*, rsp_cell_*, rsp_...  one-cycle beat on rsp_valid
//  config    csr_index, csr_wdata               write when csr_write_enable
//
//  a read passes through ram read issue, response load and beat after it is
//  accepted; a put without scroll passes through wrap check, character,
//  response load and beat; busy drops in the beat cycle, so the next request
//  can be taken at the edge that ends it
//  a scroll adds a copy pass that moves every row up, then a fill pass that
//  blanks the bottom row (a wrap and a newline in one put can scroll twice)
//  after reset the store is swept to space / 0x0F with busy high; config
//  writes are taken throughout
//  the receiver cannot stall: each response beat lives for one cycle
//
module text_console_writer #(
   parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
   parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
   input  logic                           clock,
   input  logic                           reset,
   // request
   input  logic                           start,
   output logic                           busy,
   input  logic [tcw_pkg::CMD_W-1:0]      req_cmd,
   input  logic [tcw_pkg::CH_W-1:0]       req_ch,
   input  logic [tcw_pkg::IDX_W-1:0]      req_cell_index,
   // response
   output logic                           rsp_valid,
   output logic [tcw_pkg::ROW_W-1:0]      rsp_cursor_row,
   output logic [tcw_pkg::COL_W-1:0]      rsp_cursor_col,
   output logic [tcw_pkg::POS_W-1:0]      rsp_cursor_pos,
   output logic [tcw_pkg::CH_W-1:0]       rsp_cell_char,
   output logic [tcw_pkg::ATTR_W-1:0]     rsp_cell_attr,
   output logic                           rsp_panic_flag,
   // configuration
   input  logic                           csr_write_enable,
   input  logic [tcw_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [tcw_pkg::CSR_DATA_W-1:0] csr_wdata
);

   import tcw_pkg::*;

   // geometry
   localparam int CELLS = ROWS * COLUMNS;
   localparam int AW    = $clog2(CELLS);       // ram address
   localparam int CW    = $clog2(CELLS + 1);   // counter / cursor position
   localparam int RW    = $clog2(ROWS);        // cursor row
   localparam int CLW   = $clog2(COLUMNS + 1); // cursor column, may equal COLUMNS

   localparam logic [CW-1:0]  CELLS_C    = CW'(CELLS);
   localparam logic [CW-1:0]  COLS_CW    = CW'(COLUMNS);
   localparam logic [CW-1:0]  LAST_CELL  = CW'(CELLS - 1);
   localparam logic [CW-1:0]  FILL_START = CW'(CELLS - COLUMNS);
   localparam logic [RW-1:0]  LAST_ROW   = RW'(ROWS - 1);
   localparam logic [CLW-1:0] COLS_C     = CLW'(COLUMNS);
   localparam logic [CLW-1:0] LAST_COL   = CLW'(COLUMNS - 1);

   typedef enum logic [2:0] {
      S_CLEAR,   // sweep after reset
      S_IDLE,
      S_PRE,     // read issue, or pending wrap of a put
      S_CHAR,    // character handling of a put
      S_COPY,    // scroll: move every row up by one
      S_FILL,    // scroll: blank the bottom row
      S_RESP     // load the response registers
   } state_type;

   // sequencer state
   state_type          state_ff,   state_in;
   state_type          ret_ff,     ret_in;      // where a scroll returns to
   logic [CW-1:0]      cnt_ff,     cnt_in;      // sweep / copy / fill pointer
   // cursor and colors
   logic [RW-1:0]      row_ff,     row_in;
   logic [CLW-1:0]     col_ff,     col_in;
   logic [COLOR_W-1:0] fg_ff,      fg_in;
   logic [COLOR_W-1:0] bg_ff,      bg_in;
   // captured request
   logic [CMD_W-1:0]   cmd_ff,     cmd_in;
   logic [CH_W-1:0]    ch_ff,      ch_in;
   logic [IDX_W-1:0]   idx_ff,     idx_in;
   logic               in_range_ff, in_range_in;
   logic               panic_ff,   panic_in;
   // response registers
   logic               rsp_valid_ff, rsp_valid_in;
   logic [ROW_W-1:0]   rsp_row_ff,   rsp_row_in;
   logic [COL_W-1:0]   rsp_col_ff,   rsp_col_in;
   logic [POS_W-1:0]   rsp_pos_ff,   rsp_pos_in;
   logic [CH_W-1:0]    rsp_char_ff,  rsp_char_in;
   logic [ATTR_W-1:0]  rsp_attr_ff,  rsp_attr_in;
   logic               rsp_panic_ff, rsp_panic_in;

   // ram ports, char and attr stores share the addresses
   logic              wr_char_en;
   logic              wr_attr_en;
   logic [AW-1:0]     wr_addr;
   logic [CH_W-1:0]   wr_char;
   logic [ATTR_W-1:0] wr_attr;
   logic [AW-1:0]     rd_addr;
   logic [CH_W-1:0]   rd_char;
   logic [ATTR_W-1:0] rd_attr;

   // cursor arithmetic
   logic [CW-1:0]  pos_w;
   logic [CLW:0]   tab_w;

   assign pos_w = CW'(row_ff) * COLS_CW + CW'(col_ff);
   // next multiple of four above the column
   assign tab_w = (CLW + 1)'({col_ff[CLW-1:2], 2'b00}) + (CLW + 1)'(4);

   tcw_ram #(
      .WIDTH (CH_W),
      .DEPTH (CELLS)
   ) u_char_ram (
      .clock   (clock),
      .wr_en   (wr_char_en),
      .wr_addr (wr_addr),
      .wr_data (wr_char),
      .rd_addr (rd_addr),
      .rd_data (rd_char)
   );

   tcw_ram #(
      .WIDTH (ATTR_W),
      .DEPTH (CELLS)
   ) u_attr_ram (
      .clock   (clock),
      .wr_en   (wr_attr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_attr),
      .rd_addr (rd_addr),
      .rd_data (rd_attr)
   );

   always_comb begin
      state_in     = state_ff;
      ret_in       = ret_ff;
      cnt_in       = cnt_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      fg_in        = fg_ff;
      bg_in        = bg_ff;
      cmd_in       = cmd_ff;
      ch_in        = ch_ff;
      idx_in       = idx_ff;
      in_range_in  = in_range_ff;
      panic_in     = panic_ff;
      rsp_valid_in = 1'b0;
      rsp_row_in   = rsp_row_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_pos_in   = rsp_pos_ff;
      rsp_char_in  = rsp_char_ff;
      rsp_attr_in  = rsp_attr_ff;
      rsp_panic_in = rsp_panic_ff;
      wr_char_en   = 1'b0;
      wr_attr_en   = 1'b0;
      wr_addr      = '0;
      wr_char      = '0;
      wr_attr      = '0;
      rd_addr      = '0;

      // color registers, written at any time
      if (csr_write_enable) begin
         case (csr_index)
            REG_FG_COLOR: fg_in = csr_wdata;
            REG_BG_COLOR: bg_in = csr_wdata;
            default: ;
         endcase
      end

      case (state_ff)
         S_CLEAR: begin
            wr_char_en = 1'b1;
            wr_attr_en = 1'b1;
            wr_addr    = AW'(cnt_ff);
            wr_char    = CH_SPACE;
            wr_attr    = ATTR_RESET;
            if (cnt_ff == LAST_CELL) begin
               state_in = S_IDLE;
            end else begin
               cnt_in = cnt_ff + CW'(1);
            end
         end

         S_IDLE: begin
            if (start) begin
               cmd_in   = req_cmd;
               ch_in    = req_ch;
               idx_in   = req_cell_index;
               panic_in = 1'b0;
               state_in = S_PRE;
            end
         end

         S_PRE: begin
            if (cmd_ff == CMD_READ) begin
               rd_addr     = AW'(idx_ff);
               in_range_in = (32'(idx_ff) < 32'(CELLS));
               state_in    = S_RESP;
            end else if (col_ff == COLS_C) begin
               // pending wrap before the character
               col_in = '0;
               if (row_ff == LAST_ROW) begin
                  cnt_in   = COLS_CW;
                  ret_in   = S_CHAR;
                  state_in = S_COPY;
               end else begin
                  row_in   = row_ff + RW'(1);
                  state_in = S_CHAR;
               end
            end else begin
               state_in = S_CHAR;
            end
         end

         S_CHAR: begin
            state_in = S_RESP;
            case (ch_ff)
               CH_NL: begin
                  col_in = '0;
                  if (row_ff == LAST_ROW) begin
                     cnt_in   = COLS_CW;
                     ret_in   = S_RESP;
                     state_in = S_COPY;
                  end else begin
                     row_in = row_ff + RW'(1);
                  end
               end
               CH_BS: begin
                  // one cell back in linear order, top-left stays put
                  wr_char_en = 1'b1;
                  wr_addr    = (pos_w == '0) ? '0 : AW'(pos_w - CW'(1));
                  wr_char    = CH_SPACE;
                  if (col_ff != '0) begin
                     col_in = col_ff - CLW'(1);
                  end else if (row_ff != '0) begin
                     row_in = row_ff - RW'(1);
                     col_in = LAST_COL;
                  end
               end
               CH_TAB: begin
                  if (tab_w > (CLW + 1)'(COLUMNS)) begin
                     col_in = COLS_C;
                  end else begin
                     col_in = CLW'(tab_w);
                  end
               end
               CH_ESC: begin
                  panic_in = 1'b1;
               end
               default: begin
                  wr_char_en = 1'b1;
                  wr_attr_en = 1'b1;
                  wr_addr    = AW'(pos_w);
                  wr_char    = ch_ff;
                  wr_attr    = {bg_ff, fg_ff};
                  col_in     = col_ff + CLW'(1);
               end
            endcase
         end

         S_COPY: begin
            // read cell cnt, write the cell read in the previous cycle a row up
            if (cnt_ff < CELLS_C) begin
               rd_addr = AW'(cnt_ff);
            end
            if (cnt_ff > COLS_CW) begin
               wr_char_en = 1'b1;
               wr_attr_en = 1'b1;
               wr_addr    = AW'(cnt_ff - COLS_CW - CW'(1));
               wr_char    = rd_char;
               wr_attr    = rd_attr;
            end
            if (cnt_ff == CELLS_C) begin
               cnt_in   = FILL_START;
               state_in = S_FILL;
            end else begin
               cnt_in = cnt_ff + CW'(1);
            end
         end

         S_FILL: begin
            wr_char_en = 1'b1;
            wr_attr_en = 1'b1;
            wr_addr    = AW'(cnt_ff);
            wr_char    = CH_SPACE;
            wr_attr    = ATTR_SCROLL;
            if (cnt_ff == LAST_CELL) begin
               state_in = ret_ff;
            end else begin
               cnt_in = cnt_ff + CW'(1);
            end
         end

         S_RESP: begin
            // read data of the S_PRE address is on the ram outputs now
            rsp_valid_in = 1'b1;
            rsp_row_in   = ROW_W'(row_ff);
            rsp_col_in   = COL_W'(col_ff);
            rsp_pos_in   = POS_W'(pos_w);
            rsp_panic_in = panic_ff;
            if (cmd_ff == CMD_READ && in_range_ff) begin
               rsp_char_in = rd_char;
               rsp_attr_in = rd_attr;
            end else begin
               rsp_char_in = '0;
               rsp_attr_in = '0;
            end
            state_in = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         ret_ff       <= S_RESP;
         cnt_ff       <= '0;
         row_ff       <= '0;
         col_ff       <= '0;
         fg_ff        <= FG_RESET;
         bg_ff        <= BG_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         cnt_ff       <= cnt_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         fg_ff        <= fg_in;
         bg_ff        <= bg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      // payload, no reset
      cmd_ff       <= cmd_in;
      ch_ff        <= ch_in;
      idx_ff       <= idx_in;
      in_range_ff  <= in_range_in;
      panic_ff     <= panic_in;
      rsp_row_ff   <= rsp_row_in;
      rsp_col_ff   <= rsp_col_in;
      rsp_pos_ff   <= rsp_pos_in;
      rsp_char_ff  <= rsp_char_in;
      rsp_attr_ff  <= rsp_attr_in;
      rsp_panic_ff <= rsp_panic_in;
   end

   // ready only in idle; the clearing sweep counts as busy
   assign busy           = (state_ff != S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cursor_row = rsp_row_ff;
   assign rsp_cursor_col = rsp_col_ff;
   assign rsp_cursor_pos = rsp_pos_ff;
   assign rsp_cell_char  = rsp_char_ff;
   assign rsp_cell_attr  = rsp_attr_ff;
   assign rsp_panic_flag = rsp_panic_ff;

`ifndef NO_ASSERTIONS
   // an accepted beat keeps the block busy on the next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("request accepted but block not busy");

   // response beats are single cycle strobes, never back to back
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("two response beats in a row");

   // cursor stays inside the screen, column may sit at the width
   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      (col_ff <= COLS_C) && (row_ff <= LAST_ROW))
      else $error("cursor out of range");

   // a response only follows the response state
   a_rsp_origin: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff) == S_RESP)
      else $error("response beat without response state");
`endif

endmodule

### sim/tb_text_console_writer.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_text_console_writer
// self-checking bench for the text console writer: directed reset-contents,
// control-character and color cases, then bursty random put / read traffic, every
// response beat checked field by field against a cycle-free model of screen and cursor
// ----------------------------------------------------------------------------
module tb_text_console_writer;
   import tcw_pkg::*;

   localparam int COLUMNS     = DEF_COLUMNS;
   localparam int ROWS        = DEF_ROWS;
   localparam int CELLS       = ROWS * COLUMNS;
   // covers the worst case for every command, a wrap scroll plus a newline scroll,
   // plus the sweep after reset
   localparam int CYCLE_LIMIT = 30_000_000;
   localparam int SETTLE      = 16;   // idle time after the last beat is drained
   localparam int PHASES      = 4;
   localparam int PHASE_BEATS = 495;

   // expected response beat
   typedef struct packed {
      logic [ROW_W-1:0]  row;
      logic [COL_W-1:0]  col;
      logic [POS_W-1:0]  pos;
      logic [CH_W-1:0]   chr;
      logic [ATTR_W-1:0] attr;
      logic              panic;
   } console_beat_type;

   // dut signals, all inputs known from time zero
   logic                   clock            = 1'b0;
   logic                   reset            = 1'b1;
   logic                   start            = 1'b0;
   logic                   busy;
   logic [CMD_W-1:0]       req_cmd          = CMD_PUT;
   logic [CH_W-1:0]        req_ch           = '0;
   logic [IDX_W-1:0]       req_cell_index   = '0;
   logic                   rsp_valid;
   logic [ROW_W-1:0]       rsp_cursor_row;
   logic [COL_W-1:0]       rsp_cursor_col;
   logic [POS_W-1:0]       rsp_cursor_pos;
   logic [CH_W-1:0]        rsp_cell_char;
   logic [ATTR_W-1:0]      rsp_cell_attr;
   logic                   rsp_panic_flag;
   logic                   csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index        = REG_FG_COLOR;
   logic [CSR_DATA_W-1:0]  csr_wdata        = '0;

   // screen model: cell store, cursor and color registers
   logic [CH_W-1:0]    scr_char [0:CELLS-1];
   logic [ATTR_W-1:0]  scr_attr [0:CELLS-1];
   int                 cursor_row;
   int                 cursor_col;
   logic [COLOR_W-1:0] fg_model;
   logic [COLOR_W-1:0] bg_model;

   console_beat_type pending_beats [$];   // expected beats, oldest first
   int               mismatch_count = 0;
   longint           cycle_count    = 0;

   text_console_writer uut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_cmd          (req_cmd),
      .req_ch           (req_ch),
      .req_cell_index   (req_cell_index),
      .rsp_valid        (rsp_valid),
      .rsp_cursor_row   (rsp_cursor_row),
      .rsp_cursor_col   (rsp_cursor_col),
      .rsp_cursor_pos   (rsp_cursor_pos),
      .rsp_cell_char    (rsp_cell_char),
      .rsp_cell_attr    (rsp_cell_attr),
      .rsp_panic_flag   (rsp_panic_flag),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("Regression FAIL");
      $finish;
   end

   // ---------------------------------------------------------------------
   // screen model
   // ---------------------------------------------------------------------

   function automatic void console_clear();
      for (int i = 0; i < CELLS; i++) begin
         scr_char[i] = CH_SPACE;
         scr_attr[i] = ATTR_RESET;
      end
      cursor_row = 0;
      cursor_col = 0;
      fg_model   = FG_RESET;
      bg_model   = BG_RESET;
   endfunction

   // carriage return plus line feed, scrolling off the bottom row
   function automatic void console_newline();
      cursor_col = 0;
      cursor_row++;
      if (cursor_row >= ROWS) begin
         for (int i = 0; i < CELLS - COLUMNS; i++) begin
            scr_char[i] = scr_char[i + COLUMNS];
            scr_attr[i] = scr_attr[i + COLUMNS];
         end
         // fresh bottom row gets the scroll attribute, not the current colors
         for (int i = CELLS - COLUMNS; i < CELLS; i++) begin
            scr_char[i] = CH_SPACE;
            scr_attr[i] = ATTR_SCROLL;
         end
         cursor_row = ROWS - 1;
      end
   endfunction

   // applies one command to the model and returns the beat it must answer with
   function automatic console_beat_type console_predict(logic [CMD_W-1:0] cmd,
                                                        logic [CH_W-1:0] ch,
                                                        logic [IDX_W-1:0] idx);
      console_beat_type beat;
      int               at;
      beat = '0;
      if (cmd == CMD_PUT) begin
         // pending wrap: a cursor parked past the last column wraps first,
         // whatever the character
         if (cursor_col >= COLUMNS)
            console_newline();
         case (ch)
            CH_NL: console_newline();
            CH_BS: begin
               if (cursor_col > 0) begin
                  cursor_col--;
               end else if (cursor_row > 0) begin
                  cursor_row--;
                  cursor_col = COLUMNS - 1;
               end
               // character blanked, attribute kept
               scr_char[cursor_row * COLUMNS + cursor_col] = CH_SPACE;
            end
            CH_TAB: begin
               cursor_col = (cursor_col / 4 + 1) * 4;
               if (cursor_col > COLUMNS)
                  cursor_col = COLUMNS;
            end
            CH_ESC: beat.panic = 1'b1;
            default: begin
               at = cursor_row * COLUMNS + cursor_col;
               scr_char[at] = ch;
               scr_attr[at] = {bg_model, fg_model};
               cursor_col++;
            end
         endcase
      end else if (idx < CELLS) begin
         beat.chr  = scr_char[idx];
         beat.attr = scr_attr[idx];
      end
      beat.row = ROW_W'(cursor_row);
      beat.col = COL_W'(cursor_col);
      beat.pos = POS_W'(cursor_row * COLUMNS + cursor_col);
      return beat;
   endfunction

   // ---------------------------------------------------------------------
   // response checking
   // ---------------------------------------------------------------------

   task automatic flag_mismatch(input string what, input logic [31:0] got,
                                input logic [31:0] want);
      mismatch_count++;
      $display("%0t ns mismatch %s: got %0h, expected %0h", $time, what, got, want);
   endtask

   // every response beat lives one cycle, sampled at the edge that ends it
   always @(posedge clock) begin
      console_beat_type want;
      if (!reset && rsp_valid !== 1'b0) begin
         if (pending_beats.size() == 0) begin
            flag_mismatch("response beat with nothing expected", 32'(rsp_valid), 0);
         end else begin
            want = pending_beats.pop_front();
            if (rsp_valid !== 1'b1)
               flag_mismatch("rsp_valid", 32'(rsp_valid), 1);
            if (rsp_cursor_row !== want.row)
               flag_mismatch("cursor_row", 32'(rsp_cursor_row), 32'(want.row));
            if (rsp_cursor_col !== want.col)
               flag_mismatch("cursor_col", 32'(rsp_cursor_col), 32'(want.col));
            if (rsp_cursor_pos !== want.pos)
               flag_mismatch("cursor_pos", 32'(rsp_cursor_pos), 32'(want.pos));
            if (rsp_cell_char !== want.chr)
               flag_mismatch("cell_char", 32'(rsp_cell_char), 32'(want.chr));
            if (rsp_cell_attr !== want.attr)
               flag_mismatch("cell_attr", 32'(rsp_cell_attr), 32'(want.attr));
            if (rsp_panic_flag !== want.panic)
               flag_mismatch("panic_flag", 32'(rsp_panic_flag), 32'(want.panic));
         end
      end
   end

   // ---------------------------------------------------------------------
   // drivers, all called at a rising edge
   // ---------------------------------------------------------------------

   // one command beat; start is left high so a following beat goes back to back
   task automatic send_beat(input logic [CMD_W-1:0] cmd, input logic [CH_W-1:0] ch,
                            input logic [IDX_W-1:0] idx);
      start          <= 1'b1;
      req_cmd        <= cmd;
      req_ch         <= ch;
      req_cell_index <= idx;
      @(posedge clock);
      while (busy !== 1'b0)
         @(posedge clock);
      // beat taken at this edge
      pending_beats.push_back(console_predict(cmd, ch, idx));
   endtask

   task automatic hold_off(input int cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // sender waits for every outstanding beat, then lets the block settle
   task automatic wait_drained(input int settle);
      start <= 1'b0;
      wait (pending_beats.size() == 0);
      repeat (settle) @(posedge clock);
   endtask

   // both color registers, one per cycle; block must be idle
   task automatic write_colors(input logic [COLOR_W-1:0] fg, input logic [COLOR_W-1:0] bg);
      csr_write_enable <= 1'b1;
      csr_index        <= REG_FG_COLOR;
      csr_wdata        <= fg;
      @(posedge clock);
      csr_index        <= REG_BG_COLOR;
      csr_wdata        <= bg;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      fg_model = fg;
      bg_model = bg;
   endtask

   function automatic logic [IDX_W-1:0] any_index();
      return IDX_W'($urandom_range(0, (1 << IDX_W) - 1));
   endfunction

   // ---------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------

   // store contents after the reset sweep, in and out of range
   task automatic test_reset_contents();
      send_beat(CMD_READ, 8'hFF, '0);
      send_beat(CMD_READ, 8'h00, IDX_W'(CELLS - 1));
      send_beat(CMD_READ, 8'h5A, IDX_W'(CELLS));
      send_beat(CMD_READ, 8'hA5, '1);
   endtask

   // cursor moves of every control character, wrap and boundary cases
   task automatic test_control_chars();
      send_beat(CMD_PUT, CH_BS, any_index());    // backspace at top-left stays
      send_beat(CMD_PUT, 8'h41, any_index());
      send_beat(CMD_PUT, 8'hFF, any_index());
      send_beat(CMD_PUT, 8'h00, any_index());
      send_beat(CMD_PUT, CH_TAB, any_index());   // col 3 -> 4
      send_beat(CMD_PUT, CH_TAB, any_index());   // on a tab stop -> next one
      send_beat(CMD_PUT, CH_BS, any_index());
      send_beat(CMD_PUT, CH_ESC, any_index());
      send_beat(CMD_PUT, CH_NL, any_index());
      send_beat(CMD_PUT, CH_BS, any_index());    // column 0 -> end of row above
      send_beat(CMD_PUT, 8'h7E, any_index());    // cursor parked past last column
      send_beat(CMD_READ, 8'h00, IDX_W'(COLUMNS - 1));
      send_beat(CMD_PUT, CH_NL, any_index());    // wrap plus newline: two rows
      send_beat(CMD_PUT, CH_BS, any_index());
      send_beat(CMD_PUT, CH_TAB, any_index());   // lands on the width
      send_beat(CMD_PUT, CH_BS, any_index());    // wraps, then steps back up
      send_beat(CMD_READ, 8'hFF, '0);
      send_beat(CMD_READ, 8'h00, IDX_W'(1));
   endtask

   // written attribute follows both registers at their extremes
   task automatic test_color_registers();
      wait_drained(SETTLE);
      write_colors('0, '1);
      send_beat(CMD_PUT, 8'h61, any_index());
      send_beat(CMD_READ, 8'h00, IDX_W'(cursor_row * COLUMNS + cursor_col - 1));
      wait_drained(SETTLE);
      write_colors('1, '0);
      send_beat(CMD_PUT, 8'h62, any_index());
      send_beat(CMD_READ, 8'hFF, IDX_W'(cursor_row * COLUMNS + cursor_col - 1));
   endtask

   // bursty mixed traffic in phases; each phase drains and picks new colors
   task automatic test_random_traffic();
      int                 pick;
      int                 burst_left;
      logic [CH_W-1:0]    ch;
      logic [IDX_W-1:0]   idx;
      logic [CMD_W-1:0]   cmd;
      burst_left = 0;
      for (int phase = 0; phase < PHASES; phase++) begin
         wait_drained(SETTLE);
         if (phase == PHASES - 1)
            write_colors('1, '1);
         else
            write_colors(COLOR_W'($urandom), COLOR_W'($urandom));
         for (int n = 0; n < PHASE_BEATS; n++) begin
            pick = $urandom_range(0, 99);
            cmd  = CMD_PUT;
            ch   = CH_W'($urandom);
            idx  = any_index();
            if (pick < 55) begin
               // printable byte, any value but the four controls
               while (ch == CH_NL || ch == CH_BS || ch == CH_TAB || ch == CH_ESC)
                  ch = CH_W'($urandom);
            end else if (pick < 61) begin
               ch = CH_NL;       // enough newlines to reach the bottom and scroll
            end else if (pick < 66) begin
               ch = CH_BS;
            end else if (pick < 71) begin
               ch = CH_TAB;
            end else if (pick < 73) begin
               ch = CH_ESC;
            end else begin
               cmd = CMD_READ;
               // half near the cursor row, half anywhere including past the end
               if ($urandom_range(0, 1) == 0)
                  idx = IDX_W'(cursor_row * COLUMNS + $urandom_range(0, COLUMNS - 1));
            end
            send_beat(cmd, ch, idx);
            // sender bursts: some end with no gap at all
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 40);
               if ($urandom_range(0, 9) < 7)
                  hold_off($urandom_range(1, 7));
            end else begin
               burst_left--;
            end
         end
      end
   endtask

   // ---------------------------------------------------------------------
   // sequence
   // ---------------------------------------------------------------------
   initial begin
      console_clear();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      // the reset sweep shows as busy, so the first beat simply waits
      test_reset_contents();
      test_control_chars();
      test_color_registers();
      test_random_traffic();
      wait_drained(SETTLE);
      if (mismatch_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
